>>> design/ral_pkg.sv
// Shared constants and types for the RGB auto-level stretch unit.
`timescale 1ns / 1ps

package ral_pkg;

    // Default channel width and number of color channels per pixel
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int LANES            = 3;

    // Input opcodes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_STRETCH = 1'b1;

    // How a channel result is formed at the end of the divider chain
    typedef enum logic [1:0] {
        MODE_DIV  = 2'b00,
        MODE_ZERO = 2'b01,
        MODE_FULL = 2'b10
    } mode_t;

endpackage

>>> design/ral_stats.sv
// Running per-channel minimum and maximum registers for the measure pass.
`timescale 1ns / 1ps

module ral_stats #(
    parameter int CHANNEL_BITS = ral_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           upd,
    input  logic                                           clr,
    input  logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0]    pix,
    output logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0]    low,
    output logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0]    high
);

    logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0] low_reg;
    logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0] low_next;
    logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0] high_reg;
    logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0] high_next;
    logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0] base_lo;
    logic [ral_pkg::LANES-1:0][CHANNEL_BITS-1:0] base_hi;

    // Clear on frame start, then fold the pixel into each channel
    always_comb
    begin
        for (int i = 0; i < ral_pkg::LANES; i++)
        begin
            base_lo[i]   = clr ? {CHANNEL_BITS{1'b1}} : low_reg[i];
            base_hi[i]   = clr ? {CHANNEL_BITS{1'b0}} : high_reg[i];
            low_next[i]  = low_reg[i];
            high_next[i] = high_reg[i];
            if (upd)
            begin
                low_next[i]  = (pix[i] < base_lo[i]) ? pix[i] : base_lo[i];
                high_next[i] = (pix[i] > base_hi[i]) ? pix[i] : base_hi[i];
            end
        end
    end

    // Hold the statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= {ral_pkg::LANES{{CHANNEL_BITS{1'b1}}}};
            high_reg <= {ral_pkg::LANES{{CHANNEL_BITS{1'b0}}}};
        end
        else
        begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign low  = low_reg;
    assign high = high_reg;

endmodule

>>> design/ral_prep.sv
// Front end of one channel: classify the value and build the dividend and divisor.
`timescale 1ns / 1ps

module ral_prep #(
    parameter int CHANNEL_BITS = ral_pkg::CHANNEL_BITS_DEF
) (
    input  logic [CHANNEL_BITS-1:0] pix,
    input  logic [CHANNEL_BITS-1:0] low,
    input  logic [CHANNEL_BITS-1:0] high,
    output logic [CHANNEL_BITS-1:0] rem,
    output logic [CHANNEL_BITS-1:0] dvd,
    output logic [CHANNEL_BITS-1:0] dsr,
    output ral_pkg::mode_t          mode
);

    logic [CHANNEL_BITS-1:0]   diff;
    logic [2*CHANNEL_BITS-1:0] num;

    // Flat channel or value at or below min gives zero; at or above max saturates
    always_comb
    begin
        if (high <= low || pix <= low)
            mode = ral_pkg::MODE_ZERO;
        else if (pix >= high)
            mode = ral_pkg::MODE_FULL;
        else
            mode = ral_pkg::MODE_DIV;
    end

    // Dividend is diff * (2^N - 1), formed as a shift and subtract
    assign diff = pix - low;
    assign dsr  = high - low;
    assign num  = {diff, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, diff};
    assign rem  = num[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign dvd  = num[CHANNEL_BITS-1:0];

endmodule

>>> design/ral_cell.sv
// One restoring-division cell: produces one quotient bit and passes the rest on.
`timescale 1ns / 1ps

module ral_cell #(
    parameter int CHANNEL_BITS = ral_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [CHANNEL_BITS-1:0] rem_in,
    input  logic [CHANNEL_BITS-1:0] dvd_in,
    input  logic [CHANNEL_BITS-1:0] dsr_in,
    input  logic [CHANNEL_BITS-1:0] quo_in,
    input  ral_pkg::mode_t          mode_in,
    output logic [CHANNEL_BITS-1:0] rem_out,
    output logic [CHANNEL_BITS-1:0] dvd_out,
    output logic [CHANNEL_BITS-1:0] dsr_out,
    output logic [CHANNEL_BITS-1:0] quo_out,
    output ral_pkg::mode_t          mode_out
);

    logic [CHANNEL_BITS:0]   trial;
    logic [CHANNEL_BITS:0]   diff;
    logic                    ge;
    logic [CHANNEL_BITS-1:0] rem_reg;
    logic [CHANNEL_BITS-1:0] rem_next;
    logic [CHANNEL_BITS-1:0] dvd_reg;
    logic [CHANNEL_BITS-1:0] dvd_next;
    logic [CHANNEL_BITS-1:0] dsr_reg;
    logic [CHANNEL_BITS-1:0] quo_reg;
    logic [CHANNEL_BITS-1:0] quo_next;
    ral_pkg::mode_t          mode_reg;

    // Shift in the next dividend bit and try a subtract
    assign trial    = {rem_in, dvd_in[CHANNEL_BITS-1]};
    assign diff     = trial - {1'b0, dsr_in};
    assign ge       = (trial >= {1'b0, dsr_in});
    assign rem_next = ge ? diff[CHANNEL_BITS-1:0] : trial[CHANNEL_BITS-1:0];
    assign dvd_next = {dvd_in[CHANNEL_BITS-2:0], 1'b0};
    assign quo_next = {quo_in[CHANNEL_BITS-2:0], ge};

    // Advance the word to the next cell
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= dvd_next;
            dsr_reg  <= dsr_in;
            quo_reg  <= quo_next;
            mode_reg <= mode_in;
        end
    end

    assign rem_out  = rem_reg;
    assign dvd_out  = dvd_reg;
    assign dsr_out  = dsr_reg;
    assign quo_out  = quo_reg;
    assign mode_out = mode_reg;

endmodule

>>> design/rgb_auto_level_stretch_unit.sv
// Top level of the RGB auto-level stretch unit.
//
// Input channel (in_valid / in_stall) carries one pixel word with an opcode.
// A measure word folds the pixel into per-channel min/max registers, clearing
// them first when frame_start is set; it produces no output word. A stretch
// word maps each channel to floor((v - min) * (2^N - 1) / (max - min)), with
// zero for a flat channel or a value at or below min and full scale for a
// value at or above max. Stretch results leave on the output channel
// (out_valid / out_stall) in the order their pixels came in.
// One word per clock is taken in both passes while the output is not stalled.
// A stretch word passes through one prep stage, then a row of CHANNEL_BITS
// divider cells, one quotient bit each. A stretch word reads the
// statistics left by every measure word accepted before it.
// Reset sets min to full scale, max to zero and empties the pipeline.
// When the receiver stalls, the last stage holds its word; earlier stages
// keep moving until they run into an occupied stage, and in_stall rises only
// once the first stage cannot move.
`timescale 1ns / 1ps

module rgb_auto_level_stretch_unit #(
    parameter int CHANNEL_BITS = ral_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    opcode,
    input  logic                    frame_start,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CHANNEL_BITS-1:0] red_out,
    output logic [CHANNEL_BITS-1:0] green_out,
    output logic [CHANNEL_BITS-1:0] blue_out
);

    localparam int LANES  = ral_pkg::LANES;
    localparam int STAGES = CHANNEL_BITS + 1;

    logic                                 in_accept;
    logic                                 meas_upd;
    logic [LANES-1:0][CHANNEL_BITS-1:0]   pix;
    logic [LANES-1:0][CHANNEL_BITS-1:0]   stat_lo;
    logic [LANES-1:0][CHANNEL_BITS-1:0]   stat_hi;
    logic [LANES-1:0][CHANNEL_BITS-1:0]   res;

    logic [CHANNEL_BITS-1:0] prep_rem  [LANES];
    logic [CHANNEL_BITS-1:0] prep_dvd  [LANES];
    logic [CHANNEL_BITS-1:0] prep_dsr  [LANES];
    ral_pkg::mode_t          prep_mode [LANES];

    logic [CHANNEL_BITS-1:0] rem0_reg  [LANES];
    logic [CHANNEL_BITS-1:0] dvd0_reg  [LANES];
    logic [CHANNEL_BITS-1:0] dsr0_reg  [LANES];
    ral_pkg::mode_t          mode0_reg [LANES];

    logic [CHANNEL_BITS-1:0] rem_s  [STAGES][LANES];
    logic [CHANNEL_BITS-1:0] dvd_s  [STAGES][LANES];
    logic [CHANNEL_BITS-1:0] dsr_s  [STAGES][LANES];
    logic [CHANNEL_BITS-1:0] quo_s  [STAGES][LANES];
    ral_pkg::mode_t          mode_s [STAGES][LANES];

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] rdy;

    // Stage ready chain: a stage may load when it is empty or its word moves on
    assign rdy[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
    genvar k;
    generate
        for (k = 0; k < STAGES-1; k++)
        begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate

    assign in_stall  = !rdy[0];
    assign in_accept = in_valid && !in_stall;
    assign meas_upd  = in_accept && (opcode == ral_pkg::OP_MEASURE);
    assign pix       = {blue_in, green_in, red_in};

    // Min/max statistics
    ral_stats #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (meas_upd),
        .clr   (frame_start),
        .pix   (pix),
        .low   (stat_lo),
        .high  (stat_hi)
    );

    // Advance valid bits along the chain
    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
            vld_next[0] = in_valid && (opcode == ral_pkg::OP_STRETCH);
        for (int i = 1; i < STAGES; i++)
        begin
            if (rdy[i])
                vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    genvar l;
    generate
        for (l = 0; l < LANES; l++)
        begin : g_lane
            // Classify and set up the division
            ral_prep #(
                .CHANNEL_BITS (CHANNEL_BITS)
            ) u_prep (
                .pix  (pix[l]),
                .low  (stat_lo[l]),
                .high (stat_hi[l]),
                .rem  (prep_rem[l]),
                .dvd  (prep_dvd[l]),
                .dsr  (prep_dsr[l]),
                .mode (prep_mode[l])
            );

            // Hold the prep stage
            always_ff @(posedge clk)
            begin
                if (rdy[0])
                begin
                    rem0_reg[l]  <= prep_rem[l];
                    dvd0_reg[l]  <= prep_dvd[l];
                    dsr0_reg[l]  <= prep_dsr[l];
                    mode0_reg[l] <= prep_mode[l];
                end
            end

            assign rem_s[0][l]  = rem0_reg[l];
            assign dvd_s[0][l]  = dvd0_reg[l];
            assign dsr_s[0][l]  = dsr0_reg[l];
            assign quo_s[0][l]  = '0;
            assign mode_s[0][l] = mode0_reg[l];

            // Row of divider cells, one quotient bit per cell
            for (k = 0; k < CHANNEL_BITS; k++)
            begin : g_cell
                ral_cell #(
                    .CHANNEL_BITS (CHANNEL_BITS)
                ) u_cell (
                    .clk      (clk),
                    .en       (rdy[k+1]),
                    .rem_in   (rem_s[k][l]),
                    .dvd_in   (dvd_s[k][l]),
                    .dsr_in   (dsr_s[k][l]),
                    .quo_in   (quo_s[k][l]),
                    .mode_in  (mode_s[k][l]),
                    .rem_out  (rem_s[k+1][l]),
                    .dvd_out  (dvd_s[k+1][l]),
                    .dsr_out  (dsr_s[k+1][l]),
                    .quo_out  (quo_s[k+1][l]),
                    .mode_out (mode_s[k+1][l])
                );
            end

            // Pick quotient, zero or full scale
            always_comb
            begin
                case (mode_s[STAGES-1][l])
                    ral_pkg::MODE_DIV:  res[l] = quo_s[STAGES-1][l];
                    ral_pkg::MODE_FULL: res[l] = {CHANNEL_BITS{1'b1}};
                    default:            res[l] = {CHANNEL_BITS{1'b0}};
                endcase
            end
        end
    endgenerate

    assign out_valid = vld_reg[STAGES-1];
    assign red_out   = res[0];
    assign green_out = res[1];
    assign blue_out  = res[2];

endmodule

>>> tb/ral_level_monitor.sv
// Checker for the auto-level stretch unit: predicts each stretched word and compares.
`timescale 1ns / 1ps

module ral_level_monitor #(
    parameter int CHANNEL_BITS = ral_pkg::CHANNEL_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    opcode,
    input  logic                    frame_start,
    input  logic [CHANNEL_BITS-1:0] red_in,
    input  logic [CHANNEL_BITS-1:0] green_in,
    input  logic [CHANNEL_BITS-1:0] blue_in,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [CHANNEL_BITS-1:0] red_out,
    input  logic [CHANNEL_BITS-1:0] green_out,
    input  logic [CHANNEL_BITS-1:0] blue_out,
    output int                      mismatch_count,
    output int                      pixels_owed
);

    localparam int LVL_MAX = (1 << CHANNEL_BITS) - 1;

    typedef logic [CHANNEL_BITS-1:0] level_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } pixel_t;

    // Running per-channel statistics, index 0 red, 1 green, 2 blue
    level_t low_lvl  [ral_pkg::LANES];
    level_t high_lvl [ral_pkg::LANES];

    // Stretched pixels still owed by the block, oldest first
    pixel_t stretched_q[$];

    // Map one channel value onto the full range given the measured bounds
    function automatic level_t stretch_level(level_t v, level_t lo, level_t hi);
        longint q;
        if (hi <= lo || v <= lo)
            return '0;
        if (v >= hi)
            return level_t'(LVL_MAX);
        q = ((longint'(v) - longint'(lo)) * LVL_MAX) / (longint'(hi) - longint'(lo));
        return level_t'(q);
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t px;
        pixel_t want;
        level_t lane_in [ral_pkg::LANES];
        if (!rst_n)
        begin
            for (int i = 0; i < ral_pkg::LANES; i++)
            begin
                low_lvl[i]  = level_t'(LVL_MAX);
                high_lvl[i] = '0;
            end
            stretched_q.delete();
            pixels_owed = 0;
        end
        else
        begin
            // Check an outgoing word against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (stretched_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output word %0d/%0d/%0d",
                                              red_out, green_out, blue_out));
                end
                else
                begin
                    want = stretched_q.pop_front();
                    if (red_out !== want.red)
                        report_mismatch($sformatf("red_out: got %0d, expected %0d",
                                                  red_out, want.red));
                    if (green_out !== want.green)
                        report_mismatch($sformatf("green_out: got %0d, expected %0d",
                                                  green_out, want.green));
                    if (blue_out !== want.blue)
                        report_mismatch($sformatf("blue_out: got %0d, expected %0d",
                                                  blue_out, want.blue));
                end
            end

            // Fold a measure word into the statistics or predict a stretch word
            if (in_valid && !in_stall)
            begin
                lane_in[0] = red_in;
                lane_in[1] = green_in;
                lane_in[2] = blue_in;
                if (opcode == ral_pkg::OP_MEASURE)
                begin
                    for (int i = 0; i < ral_pkg::LANES; i++)
                    begin
                        if (frame_start)
                        begin
                            low_lvl[i]  = level_t'(LVL_MAX);
                            high_lvl[i] = '0;
                        end
                        if (lane_in[i] < low_lvl[i])
                            low_lvl[i] = lane_in[i];
                        if (lane_in[i] > high_lvl[i])
                            high_lvl[i] = lane_in[i];
                    end
                end
                else
                begin
                    px.red   = stretch_level(lane_in[0], low_lvl[0], high_lvl[0]);
                    px.green = stretch_level(lane_in[1], low_lvl[1], high_lvl[1]);
                    px.blue  = stretch_level(lane_in[2], low_lvl[2], high_lvl[2]);
                    stretched_q.push_back(px);
                end
            end
            pixels_owed = stretched_q.size();
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the RGB auto-level stretch unit: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int CHANNEL_BITS  = ral_pkg::CHANNEL_BITS_DEF;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 4 * (CHANNEL_BITS + 1);
    localparam int ITEM_TARGET   = 1500;
    localparam int QUIET_AFTER   = 1300;

    typedef logic [CHANNEL_BITS-1:0] level_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    logic   opcode;
    logic   frame_start;
    level_t red_in;
    level_t green_in;
    level_t blue_in;
    logic   out_valid;
    logic   out_stall = 1'b0;
    level_t red_out;
    level_t green_out;
    level_t blue_out;

    int mismatch_count;
    int pixels_owed;
    int cycle_count;
    int items_sent;
    int gap_odds;    // 0: no input gaps, else a gap before one word in gap_odds
    int stall_odds;  // 0: no output stalls, else a stall burst starts one cycle in stall_odds
    int stall_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rgb_auto_level_stretch_unit #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .frame_start (frame_start),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out)
    );

    ral_level_monitor #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .frame_start    (frame_start),
        .red_in         (red_in),
        .green_in       (green_in),
        .blue_in        (blue_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .red_out        (red_out),
        .green_out      (green_out),
        .blue_out       (blue_out),
        .mismatch_count (mismatch_count),
        .pixels_owed    (pixels_owed)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stall the output side in randomly started bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(4, 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Present one pixel word and hold it until the block takes it
    task automatic put_word(logic op, logic fs, level_t r, level_t g, level_t b);
        if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0)
        begin
            repeat ($urandom_range(5, 1))
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        frame_start <= fs;
        red_in      <= r;
        green_in    <= g;
        blue_in     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic int pick_odds();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 2;
            2:       return 4;
            default: return 8;
        endcase
    endfunction

    initial
    begin
        level_t lo  [ral_pkg::LANES];
        level_t hi  [ral_pkg::LANES];
        level_t val [ral_pkg::LANES];
        int     kind;
        int     n_words;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        opcode      = ral_pkg::OP_MEASURE;
        frame_start = 1'b0;
        red_in      = '0;
        green_in    = '0;
        blue_in     = '0;
        gap_odds    = 0;
        stall_odds  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty statistics after reset: every channel stretches to zero
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd0,   8'd0,   8'd0);
        put_word(ral_pkg::OP_STRETCH, 1'b1, 8'd255, 8'd255, 8'd255);
        // One pixel measured without a frame start: flat channels
        put_word(ral_pkg::OP_MEASURE, 1'b0, 8'd10,  8'd20,  8'd30);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd10,  8'd20,  8'd30);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd11,  8'd25,  8'd255);
        // Full-range red and green, flat blue
        put_word(ral_pkg::OP_MEASURE, 1'b1, 8'd0,   8'd255, 8'd128);
        put_word(ral_pkg::OP_MEASURE, 1'b0, 8'd255, 8'd0,   8'd128);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd0,   8'd255, 8'd128);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd255, 8'd0,   8'd7);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd127, 8'd128, 8'd200);
        // Narrow range: below, at and above the bounds, then inside
        put_word(ral_pkg::OP_MEASURE, 1'b1, 8'd50,  8'd100, 8'd150);
        put_word(ral_pkg::OP_MEASURE, 1'b0, 8'd150, 8'd200, 8'd250);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd49,  8'd99,  8'd149);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd50,  8'd100, 8'd150);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd150, 8'd200, 8'd250);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd151, 8'd201, 8'd251);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd99,  8'd151, 8'd201);
        // Frame start on a stretch word leaves the statistics alone
        put_word(ral_pkg::OP_STRETCH, 1'b1, 8'd100, 8'd150, 8'd200);
        put_word(ral_pkg::OP_MEASURE, 1'b0, 8'd0,   8'd0,   8'd255);
        put_word(ral_pkg::OP_STRETCH, 1'b0, 8'd1,   8'd1,   8'd254);

        // Random frames: measure pass, then stretch pass; some noise bursts
        gap_odds   = 4;
        stall_odds = 4;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_AFTER)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else if ($urandom_range(3, 0) == 0)
            begin
                gap_odds   = pick_odds();
                stall_odds = pick_odds();
            end
            kind = $urandom_range(9, 0);
            if (kind == 0)
            begin
                n_words = $urandom_range(16, 1);
                repeat (n_words)
                    put_word(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                             level_t'($urandom_range(255, 0)),
                             level_t'($urandom_range(255, 0)),
                             level_t'($urandom_range(255, 0)));
            end
            else
            begin
                for (int i = 0; i < ral_pkg::LANES; i++)
                begin
                    if (kind == 1)
                    begin
                        lo[i] = 8'd0;
                        hi[i] = 8'd255;
                    end
                    else
                    begin
                        lo[i] = level_t'($urandom_range(255, 0));
                        hi[i] = level_t'($urandom_range(255, lo[i]));
                    end
                end
                n_words = $urandom_range(12, 1);
                for (int w = 0; w < n_words; w++)
                begin
                    for (int i = 0; i < ral_pkg::LANES; i++)
                        val[i] = level_t'($urandom_range(hi[i], lo[i]));
                    put_word(ral_pkg::OP_MEASURE, w == 0, val[0], val[1], val[2]);
                end
                n_words = $urandom_range(12, 1);
                repeat (n_words)
                begin
                    for (int i = 0; i < ral_pkg::LANES; i++)
                        val[i] = ($urandom_range(3, 0) == 0)
                                 ? level_t'($urandom_range(255, 0))
                                 : level_t'($urandom_range(hi[i], lo[i]));
                    put_word(ral_pkg::OP_STRETCH, 1'($urandom_range(1, 0)),
                             val[0], val[1], val[2]);
                end
            end
        end
        in_valid <= 1'b0;

        // Drain the pipeline, then give late words a chance to show up
        while (pixels_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
